### rtl/lfps_pkg.sv
package lfps_pkg;

  localparam int CHANNEL_COUNT    = 8;
  localparam int CNT_W            = 4;
  localparam int SUM_W            = 5;
  localparam int SLOWDOWN_GAIN_Q8 = 256;
  localparam int CENTER_Q8        = (CHANNEL_COUNT - 1) * 128;
  localparam int QUEUE_DEPTH      = 2;
  localparam int DIV_W            = 32;
  localparam int IN_W             = 80;
  localparam int OUT_W            = 64;

  localparam logic [1:0] REASON_NONE  = 2'd0;
  localparam logic [1:0] REASON_STALE = 2'd1;
  localparam logic [1:0] REASON_LOST  = 2'd2;

  typedef enum logic [2:0] {
    REG_MIN_CH,
    REG_TIMEOUT,
    REG_DETECT_DEB,
    REG_LOST_DEB,
    REG_PROP_GAIN,
    REG_DERIV_GAIN,
    REG_ANG_LIMIT,
    REG_BASE_SPEED
  } reg_idx_e;

  typedef enum logic [2:0] {
    KIND_STALE,
    KIND_REPEAT,
    KIND_LOST,
    KIND_PENDING,
    KIND_COMMAND
  } kind_e;

  typedef struct packed {
    logic [3:0]  min_ch;
    logic [15:0] timeout;
    logic [7:0]  detect_deb;
    logic [7:0]  lost_deb;
    logic [15:0] prop_gain;
    logic [15:0] deriv_gain;
    logic [14:0] ang_limit;
    logic [11:0] base_speed;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic              release_req;
    logic              restart;
    logic [CNT_W-1:0]  count;
    logic [SUM_W-1:0]  sum;
    logic [31:0]       ts;
  } job_t;

  typedef struct packed {
    logic [3:0]         active_count;
    logic signed [10:0] line_error_q8;
    logic [10:0]        line_position_q8;
    logic               steer_saturated;
    logic [11:0]        forward_speed;
    logic signed [15:0] steer_rate_q8;
    logic               command_valid;
    logic               release_request;
    logic [1:0]         loss_cause;
    logic               tracking_on;
  } res_t;

endpackage

### rtl/lfps_front.sv
module lfps_front import lfps_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [IN_W-1:0] in_data_i,
  input  logic            full_i,
  output logic            push_o,
  output job_t            job_o
);

  logic [7:0]       seen_q, seen_d;
  logic [7:0]       lost_q, lost_d;
  logic [31:0]      lpt_q, lpt_d;
  logic [7:0]       bits;
  logic             valid, restart;
  logic [31:0]      ts, now, age;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] sum;
  logic [7:0]       seen_eff, lost_eff, seen_inc, lost_inc;
  logic [31:0]      lpt_eff;

  assign bits    = in_data_i[7:0];
  assign valid   = in_data_i[8];
  assign ts      = in_data_i[40:9];
  assign now     = in_data_i[72:41];
  assign restart = in_data_i[73];
  assign age     = now - ts;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && in_ready_o;

  // channel count and index sum
  always_comb begin
    cnt = '0;
    sum = '0;
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      if (bits[i]) begin
        cnt = cnt + CNT_W'(1);
        sum = sum + SUM_W'(i);
      end
    end
  end

  assign seen_eff = restart ? 8'd0 : seen_q;
  assign lost_eff = restart ? 8'd0 : lost_q;
  assign lpt_eff  = restart ? 32'd0 : lpt_q;
  assign seen_inc = (seen_eff == 8'd255) ? seen_eff : seen_eff + 8'd1;
  assign lost_inc = (lost_eff == 8'd255) ? lost_eff : lost_eff + 8'd1;

  always_comb begin
    seen_d            = seen_eff;
    lost_d            = lost_eff;
    lpt_d             = lpt_eff;
    job_o.kind        = KIND_REPEAT;
    job_o.release_req = 1'b0;
    job_o.restart     = restart;
    job_o.count       = cnt;
    job_o.sum         = sum;
    job_o.ts          = ts;
    priority if (!valid || (ts != 32'd0 && age > {16'd0, cfg_i.timeout})) begin
      job_o.kind        = KIND_STALE;
      job_o.release_req = (ts != 32'd0);
    end else if (ts == lpt_eff) begin
      job_o.kind = KIND_REPEAT;
    end else if (cnt == '0 || cnt < cfg_i.min_ch) begin
      lpt_d             = ts;
      seen_d            = 8'd0;
      lost_d            = lost_inc;
      job_o.kind        = KIND_LOST;
      job_o.release_req = (lost_inc >= cfg_i.lost_deb);
    end else begin
      lpt_d      = ts;
      lost_d     = 8'd0;
      seen_d     = seen_inc;
      job_o.kind = (seen_inc < cfg_i.detect_deb) ? KIND_PENDING : KIND_COMMAND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      lost_q <= '0;
      lpt_q  <= '0;
    end else if (push_o) begin
      seen_q <= seen_d;
      lost_q <= lost_d;
      lpt_q  <= lpt_d;
    end
  end

endmodule

### rtl/lfps_queue.sv
module lfps_queue import lfps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(QUEUE_DEPTH + 1);

  job_t               mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W_Q-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W_Q'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W_Q'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W_Q'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !full_o) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W_Q'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

### rtl/lfps_div.sv
module lfps_div import lfps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] numer_i,
  input  logic [DIV_W-1:0] denom_i,
  input  logic [5:0]       steps_i,
  output logic             busy_o,
  output logic [DIV_W-1:0] quot_o
);

  // numerator arrives left aligned; one quotient bit per cycle
  logic [DIV_W:0]   rem_q, trial;
  logic [DIV_W-1:0] quo_q, den_q;
  logic [5:0]       cnt_q;
  logic             busy_q, fits;

  assign trial  = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
  assign fits   = (trial >= {1'b0, den_q});
  assign busy_o = busy_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 6'd1;
      busy_q <= (cnt_q != 6'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= numer_i;
      den_q <= denom_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial - {1'b0, den_q} : trial;
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

endmodule

### rtl/lfps_back.sv
module lfps_back import lfps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic empty_i,
  input  job_t job_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_POS, ST_DER, ST_DER_WAIT, ST_SPD, ST_MULD, ST_SUM, ST_CLAMP, ST_FIN
  } state_e;

  state_e             state_q;
  job_t               job_q;
  res_t               res_q;
  res_t               idle_res;
  logic               out_valid_q, out_free, out_set;
  logic [31:0]        prev_time_q;
  logic signed [11:0] prev_err_q;
  logic [10:0]        pos_q;
  logic signed [10:0] err_q;
  logic signed [21:0] deriv_q;
  logic               der_neg_q;
  logic signed [27:0] p1_q;
  logic signed [38:0] p2_q;
  logic signed [39:0] raw_q;
  logic signed [15:0] steer_q;
  logic               sat_q;

  logic             div_start, div_busy;
  logic [DIV_W-1:0] div_numer, div_denom, div_quot;
  logic [5:0]       div_steps;

  logic [12:0]        pos_num;
  logic signed [11:0] diff;
  logic [10:0]        diff_mag;
  logic [20:0]        der_num;
  logic [9:0]         abs_err;
  logic [11:0]        err_w;
  logic signed [39:0] lim, steer_full;
  logic               use_der;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;
  assign pop_o       = (state_q == ST_IDLE) && !empty_i && out_free;
  assign out_set     = (pop_o && (job_i.kind != KIND_COMMAND)) ||
                       ((state_q == ST_FIN) && !div_busy && out_free);

  assign pos_num  = {job_i.sum, 8'd0} + {9'd0, job_i.count[CNT_W-1:1]};
  assign diff     = {err_q[10], err_q} - prev_err_q;
  assign diff_mag = diff[11] ? 11'(-diff) : diff[10:0];
  assign der_num  = {10'd0, diff_mag} * 21'd1000;
  assign abs_err  = err_q[10] ? 10'(-err_q) : err_q[9:0];
  assign err_w    = 12'(CENTER_Q8) - {1'b0, div_quot[10:0]};
  assign use_der  = (prev_time_q != 32'd0) && (job_q.ts != prev_time_q);
  assign lim      = {17'd0, cfg_i.ang_limit, 8'd0};
  assign steer_full = raw_q[39] ? (raw_q + 40'sd255) >>> 8 : raw_q >>> 8;

  // result of a frame that gives no command
  always_comb begin
    idle_res                 = '0;
    idle_res.active_count    = (job_i.kind == KIND_LOST || job_i.kind == KIND_PENDING)
                               ? job_i.count : '0;
    idle_res.loss_cause      = (job_i.kind == KIND_STALE) ? REASON_STALE :
                               (job_i.kind == KIND_LOST)  ? REASON_LOST  : REASON_NONE;
    idle_res.release_request = job_i.release_req;
  end

  lfps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (div_numer),
    .denom_i (div_denom),
    .steps_i (div_steps),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  always_comb begin
    div_start = 1'b0;
    div_numer = {pos_num, 19'd0};
    div_denom = {28'd0, job_i.count};
    div_steps = 6'd13;
    unique case (state_q)
      ST_IDLE: div_start = pop_o && (job_i.kind == KIND_COMMAND);
      ST_DER: begin
        div_start = use_der;
        div_numer = {der_num, 11'd0};
        div_denom = job_q.ts - prev_time_q;
        div_steps = 6'd21;
      end
      ST_SPD: begin
        div_start = 1'b1;
        div_numer = {cfg_i.base_speed, 16'd0, 4'd0};
        div_denom = 32'd65536 + 32'(SLOWDOWN_GAIN_Q8) * {22'd0, abs_err};
        div_steps = 6'd28;
      end
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      prev_time_q <= '0;
      prev_err_q  <= '0;
      res_q       <= '0;
      job_q       <= '0;
      pos_q       <= '0;
      err_q       <= '0;
      deriv_q     <= '0;
      der_neg_q   <= 1'b0;
      p1_q        <= '0;
      p2_q        <= '0;
      raw_q       <= '0;
      steer_q     <= '0;
      sat_q       <= 1'b0;
    end else begin
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            job_q <= job_i;
            if (job_i.restart) begin
              prev_time_q <= '0;
            end
            if (job_i.kind == KIND_COMMAND) begin
              state_q <= ST_POS;
            end else begin
              res_q <= idle_res;
            end
          end
        end
        ST_POS: begin
          if (!div_busy) begin
            pos_q   <= div_quot[10:0];
            err_q   <= err_w[10:0];
            state_q <= ST_DER;
          end
        end
        ST_DER: begin
          der_neg_q <= diff[11];
          deriv_q   <= '0;
          state_q   <= use_der ? ST_DER_WAIT : ST_SPD;
        end
        ST_DER_WAIT: begin
          if (!div_busy) begin
            deriv_q <= der_neg_q ? -$signed({1'b0, div_quot[20:0]})
                                 : $signed({1'b0, div_quot[20:0]});
            state_q <= ST_SPD;
          end
        end
        ST_SPD: begin
          p1_q    <= $signed({1'b0, cfg_i.prop_gain}) * err_q;
          state_q <= ST_MULD;
        end
        ST_MULD: begin
          p2_q    <= $signed({1'b0, cfg_i.deriv_gain}) * deriv_q;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          raw_q   <= 40'(p1_q) + 40'(p2_q);
          state_q <= ST_CLAMP;
        end
        ST_CLAMP: begin
          priority if (raw_q > lim) begin
            sat_q   <= 1'b1;
            steer_q <= $signed({1'b0, cfg_i.ang_limit});
          end else if (raw_q < -lim) begin
            sat_q   <= 1'b1;
            steer_q <= -$signed({1'b0, cfg_i.ang_limit});
          end else begin
            sat_q   <= 1'b0;
            steer_q <= steer_full[15:0];
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!div_busy && out_free) begin
            res_q.tracking_on      <= 1'b1;
            res_q.loss_cause       <= REASON_NONE;
            res_q.release_request  <= 1'b0;
            res_q.command_valid    <= 1'b1;
            res_q.steer_rate_q8    <= steer_q;
            res_q.forward_speed    <= div_quot[11:0];
            res_q.steer_saturated  <= sat_q;
            res_q.line_position_q8 <= pos_q;
            res_q.line_error_q8    <= err_q;
            res_q.active_count     <= job_q.count;
            prev_err_q             <= {err_q[10], err_q};
            prev_time_q            <= job_q.ts;
            state_q                <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_track_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.tracking_on |-> res_q.command_valid &&
    res_q.loss_cause == REASON_NONE && !res_q.release_request)
    else $error("tracking result with inconsistent flags");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(res_q))
    else $error("pending result overwritten");
`endif

endmodule

### rtl/line_follow_pd_steering.sv
// line follower pd steering: one result per accepted frame, in order
// stale, repeated, lost and pending frames: one per cycle while the output is free;
//   a steering frame uses the shared serial divider for position, the error rate
//   when one is taken, and speed (one quotient bit a cycle: 13 position, 21 error rate,
//   28 speed steps); a 2-entry queue holds further frames meanwhile
// reset: async active low; streaks and time history cleared, registers to defaults
module line_follow_pd_steering import lfps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration write port
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [15:0]      cfg_data_i,
  // input frames
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // channel_bits[7:0], sample_valid[8], frame_time[40:9], now_ms[72:41],
  // restart_history[73], zero fill[79:74]
  input  logic [IN_W-1:0]  s_axis_tdata,
  // results
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // tracking_on[0], loss_cause[2:1], release_request[3], command_valid[4],
  // steer_rate_q8[20:5], forward_speed[32:21], steer_saturated[33],
  // line_position_q8[44:34], line_error_q8[55:45], active_count[59:56], zero[63:60]
  output logic [OUT_W-1:0] m_axis_tdata
);

  cfg_t cfg_q;
  job_t front_job, queue_job;
  logic push, full, pop, empty;
  res_t res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_ch     <= 4'd1;
      cfg_q.timeout    <= 16'd100;
      cfg_q.detect_deb <= 8'd1;
      cfg_q.lost_deb   <= 8'd3;
      cfg_q.prop_gain  <= 16'd256;
      cfg_q.deriv_gain <= 16'd0;
      cfg_q.ang_limit  <= 15'd512;
      cfg_q.base_speed <= 12'd200;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_MIN_CH:     cfg_q.min_ch     <= cfg_data_i[3:0];
        REG_TIMEOUT:    cfg_q.timeout    <= cfg_data_i;
        REG_DETECT_DEB: cfg_q.detect_deb <= cfg_data_i[7:0];
        REG_LOST_DEB:   cfg_q.lost_deb   <= cfg_data_i[7:0];
        REG_PROP_GAIN:  cfg_q.prop_gain  <= cfg_data_i;
        REG_DERIV_GAIN: cfg_q.deriv_gain <= cfg_data_i;
        REG_ANG_LIMIT:  cfg_q.ang_limit  <= cfg_data_i[14:0];
        REG_BASE_SPEED: cfg_q.base_speed <= cfg_data_i[11:0];
        default:        cfg_q.min_ch     <= cfg_q.min_ch;
      endcase
    end
  end

  // front: classify the frame, keep streaks and last sample time
  lfps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .full_i     (full),
    .push_o     (push),
    .job_o      (front_job)
  );

  // decouples classification from the slow arithmetic
  lfps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (queue_job)
  );

  // back: centroid, pd law, speed, output register
  lfps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .job_i       (queue_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  assign m_axis_tdata = {4'd0, res};

endmodule

### tb/line_follow_pd_steering_tb.sv
module line_follow_pd_steering_tb;
  import lfps_pkg::*;

  // one sensor frame as it enters the block
  typedef struct {
    logic [7:0]  bits;
    logic        valid;
    logic [31:0] ts;
    logic [31:0] now;
    logic        restart;
  } frame_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  reg_idx_e        cfg_idx_i = REG_MIN_CH;
  logic [15:0]     cfg_data_i = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  line_follow_pd_steering u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // frames waiting to be offered, and the results they should produce
  frame_t pending_frames[$];
  res_t   expected_results[$];
  int     errors = 0;
  bit     calm = 1'b0;   // no idling on either side

  // register shadow, mirrors the block's defaults
  int unsigned min_ch = 1, timeout_ms = 100, detect_deb = 1, lost_deb = 3;
  int unsigned prop_gain = 256, deriv_gain = 0, ang_limit = 512, base_speed = 200;

  // steering history kept by the predictor
  int unsigned       seen_run = 0, lost_run = 0;
  logic signed [11:0] last_error = '0;
  logic [31:0]       last_cmd_ts = '0, last_seen_ts = '0;

  // work out the result of one accepted frame and advance the history
  function automatic res_t steer_predict(frame_t f);
    res_t r;
    int unsigned cnt, sum, pos;
    longint err, rate, raw, lim, abs_err;
    logic [31:0] age, dt;
    r = '0;
    cnt = 0;
    sum = 0;
    rate = 0;
    if (f.restart) begin
      seen_run = 0;
      lost_run = 0;
      last_cmd_ts = '0;
      last_seen_ts = '0;
    end
    age = f.now - f.ts;
    // stale sample: nothing in the history moves
    if (!f.valid || (f.ts != 0 && age > timeout_ms)) begin
      r.loss_cause = REASON_STALE;
      r.release_request = (f.ts != 0);
      return r;
    end
    // same time stamp as the last frame processed: an all-zero result
    if (f.ts == last_seen_ts) return r;
    last_seen_ts = f.ts;
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      if (f.bits[i]) begin
        sum += i;
        cnt++;
      end
    end
    r.active_count = 4'(cnt);
    if (cnt == 0 || cnt < min_ch) begin
      seen_run = 0;
      if (lost_run < 255) lost_run++;
      r.loss_cause = REASON_LOST;
      r.release_request = (lost_run >= lost_deb);
      return r;
    end
    lost_run = 0;
    if (seen_run < 255) seen_run++;
    if (seen_run < detect_deb) return r;
    pos = (sum * 256 + cnt / 2) / cnt;
    err = longint'(CENTER_Q8) - longint'(pos);
    if (last_cmd_ts != 0 && f.ts != last_cmd_ts) begin
      dt = f.ts - last_cmd_ts;
      rate = (err - longint'(last_error)) * 1000 / longint'({32'd0, dt});
    end
    raw = longint'(prop_gain) * err + longint'(deriv_gain) * rate;
    lim = longint'(ang_limit) * 256;
    if (raw > lim) begin
      r.steer_saturated = 1'b1;
      r.steer_rate_q8 = 16'(ang_limit);
    end else if (raw < -lim) begin
      r.steer_saturated = 1'b1;
      r.steer_rate_q8 = 16'(-longint'(ang_limit));
    end else begin
      r.steer_rate_q8 = 16'(raw / 256);
    end
    abs_err = err < 0 ? -err : err;
    r.forward_speed = 12'(longint'(base_speed) * 65536 /
                          (65536 + longint'(SLOWDOWN_GAIN_Q8) * abs_err));
    r.tracking_on = 1'b1;
    r.command_valid = 1'b1;
    r.line_position_q8 = 11'(pos);
    r.line_error_q8 = 11'(err);
    last_error = 12'(err);
    last_cmd_ts = f.ts;
    return r;
  endfunction

  // driver: offers queued frames, predicts each one as it is accepted
  frame_t cur_frame;
  int     tx_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(steer_predict(cur_frame));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap == 0 && !calm && $urandom_range(0, 9) == 0)
          tx_gap = $urandom_range(1, 7);
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_frames.size() > 0) begin
          cur_frame = pending_frames.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'd0, cur_frame.restart, cur_frame.now, cur_frame.ts,
                           cur_frame.valid, cur_frame.bits};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // monitor: compares every result with the oldest expectation,
  // and paces its ready with stalls and one long hold
  int rx_count, rx_stall, rx_hold;
  bit hold_done;
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_count = 0;
      rx_stall = 0;
      rx_hold = 0;
      hold_done = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[59:0]);
        rx_count++;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("tracking_on", longint'(want.tracking_on),
                      longint'(got.tracking_on));
          check_field("loss_cause", longint'(want.loss_cause), longint'(got.loss_cause));
          check_field("release_request", longint'(want.release_request),
                      longint'(got.release_request));
          check_field("command_valid", longint'(want.command_valid),
                      longint'(got.command_valid));
          check_field("steer_rate_q8", longint'(want.steer_rate_q8),
                      longint'(got.steer_rate_q8));
          check_field("forward_speed", longint'(want.forward_speed),
                      longint'(got.forward_speed));
          check_field("steer_saturated", longint'(want.steer_saturated),
                      longint'(got.steer_saturated));
          check_field("line_position_q8", longint'(want.line_position_q8),
                      longint'(got.line_position_q8));
          check_field("line_error_q8", longint'(want.line_error_q8),
                      longint'(got.line_error_q8));
          check_field("active_count", longint'(want.active_count),
                      longint'(got.active_count));
        end
      end
      // long hold once, so the front queue fills and input stalls
      if (!hold_done && rx_count == 300) begin
        hold_done = 1'b1;
        rx_hold = 400;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        if (rx_stall == 0 && $urandom_range(0, 7) == 0) rx_stall = $urandom_range(1, 7);
        if (rx_stall > 0) rx_stall--;
        m_axis_tready <= (rx_stall == 0);
      end
    end
  end

  // stimulus helpers
  logic [31:0] t_ms;   // time cursor for well-formed runs

  task automatic push_frame(logic [7:0] bits, logic valid, logic [31:0] ts,
                            logic [31:0] now, logic restart);
    frame_t f;
    f.bits = bits;
    f.valid = valid;
    f.ts = ts;
    f.now = now;
    f.restart = restart;
    pending_frames.push_back(f);
  endtask

  function automatic logic [7:0] rand_bits();
    int w;
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'h01 << $urandom_range(0, 7);
      2, 3, 4: begin
        w = $urandom_range(1, 3);
        return ((8'h01 << w) - 8'h01) << $urandom_range(0, 8 - w);
      end
      5: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_random();
    logic [31:0] ts, now;
    int sel;
    sel = $urandom_range(0, 99);
    t_ms += $urandom_range(1, 60);
    ts = t_ms;
    now = ts + $urandom_range(0, timeout_ms);
    if (sel < 4) now = ts + timeout_ms + $urandom_range(1, 1000);   // stale by age
    else if (sel < 7) ts = 32'd0;                                   // unknown time
    else if (sel < 10) ts = t_ms - 32'd1;                           // repeat or older
    else if (sel < 12) begin
      ts = $urandom;
      now = $urandom;                                               // anything goes
    end
    push_frame(rand_bits(), sel != 12 && sel != 13, ts, now, $urandom_range(0, 49) == 0);
  endtask

  task automatic cfg_write(reg_idx_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= 16'(val);
    case (idx)
      REG_MIN_CH:     min_ch = val & 32'hF;
      REG_TIMEOUT:    timeout_ms = val & 32'hFFFF;
      REG_DETECT_DEB: detect_deb = val & 32'hFF;
      REG_LOST_DEB:   lost_deb = val & 32'hFF;
      REG_PROP_GAIN:  prop_gain = val & 32'hFFFF;
      REG_DERIV_GAIN: deriv_gain = val & 32'hFFFF;
      REG_ANG_LIMIT:  ang_limit = val & 32'h7FFF;
      default:        base_speed = val & 32'hFFF;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(int unsigned mc, int unsigned tmo, int unsigned dd, int unsigned ld,
                         int unsigned pg, int unsigned dg, int unsigned al, int unsigned bs);
    cfg_write(REG_MIN_CH, mc);
    cfg_write(REG_TIMEOUT, tmo);
    cfg_write(REG_DETECT_DEB, dd);
    cfg_write(REG_LOST_DEB, ld);
    cfg_write(REG_PROP_GAIN, pg);
    cfg_write(REG_DERIV_GAIN, dg);
    cfg_write(REG_ANG_LIMIT, al);
    cfg_write(REG_BASE_SPEED, bs);
  endtask

  // block is idle once nothing is queued, offered or awaited, plus its latency
  task automatic drain();
    while (pending_frames.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic run_random(int n);
    repeat (n) push_random();
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames at the reset settings
    push_frame(8'h18, 1'b1, 32'd0, 32'd5, 1'b0);          // time 0 right after reset
    push_frame(8'h00, 1'b0, 32'd10, 32'd10, 1'b0);        // invalid with a time
    push_frame(8'h01, 1'b0, 32'd0, 32'd10, 1'b0);         // invalid, unknown time
    push_frame(8'h01, 1'b1, 32'd10, 32'd200, 1'b0);       // too old
    push_frame(8'h01, 1'b1, 32'd20, 32'd20, 1'b0);        // far right edge
    push_frame(8'h80, 1'b1, 32'd40, 32'd60, 1'b0);        // far left edge
    push_frame(8'h80, 1'b1, 32'd40, 32'd60, 1'b0);        // repeated time
    push_frame(8'hFF, 1'b1, 32'd41, 32'd141, 1'b0);       // all channels, age at limit
    push_frame(8'h00, 1'b1, 32'd50, 32'd50, 1'b0);        // lost
    push_frame(8'h00, 1'b1, 32'd51, 32'd50, 1'b0);        // stale, now behind sample
    push_frame(8'h00, 1'b1, 32'd52, 32'd52, 1'b0);        // lost again
    push_frame(8'h81, 1'b1, 32'd53, 32'd53, 1'b0);
    push_frame(8'h18, 1'b1, 32'd54, 32'd54, 1'b1);        // restart clears history
    push_frame(8'h06, 1'b1, 32'hFFFF_FFF0, 32'hFFFF_FFF8, 1'b0);
    push_frame(8'h60, 1'b1, 32'h0000_0005, 32'h0000_0010, 1'b0);  // time wraps
    push_frame(8'hAA, 1'b1, 32'hFFFF_FFFF, 32'h0000_0063, 1'b0);  // age wraps
    push_frame(8'h55, 1'b1, 32'h8000_0000, 32'h8000_0000, 1'b0);
    drain();

    // high gains and a derivative, narrow limit
    set_all(1, 65535, 0, 0, 65535, 65535, 1, 4095);
    t_ms = 32'hFFFF_F000;
    run_random(260);

    // demanding detection and long debounces
    set_all(8, 1, 255, 255, 0, 0, 32767, 0);
    t_ms = $urandom;
    run_random(120);
    set_all(4, 200, 3, 2, 300, 2000, 32767, 1000);
    t_ms = 32'd1000;
    run_random(300);

    // a run long enough to saturate the seen streak
    set_all(1, 1000, 255, 1, 256, 64, 2000, 300);
    repeat (280) begin
      t_ms += $urandom_range(1, 20);
      push_frame(rand_bits() | 8'h08, 1'b1, t_ms, t_ms, 1'b0);
    end
    drain();

    // zero and over-range channel minimums
    set_all(0, 50, 1, 3, 512, 100, 8000, 2500);
    run_random(150);
    cfg_write(REG_MIN_CH, 15);
    run_random(100);

    // random settings
    repeat (3) begin
      set_all($urandom_range(1, 8), $urandom_range(1, 65535), $urandom_range(0, 5),
              $urandom_range(0, 5), $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(1, 32767), $urandom_range(0, 4095));
      t_ms = $urandom;
      run_random(150);
    end

    // last stretch with no idling
    calm = 1'b1;
    set_all(2, 300, 1, 2, 700, 3000, 20000, 3000);
    run_random(200);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40000000;
    $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
rtl/lfps_pkg.sv
rtl/lfps_front.sv
rtl/lfps_queue.sv
rtl/lfps_div.sv
rtl/lfps_back.sv
rtl/line_follow_pd_steering.sv
tb/line_follow_pd_steering_tb.sv
